// ===== design/weighted_random_selector_assert.svh =====
// Assertion macros shared by the weighted random selector modules.
`ifndef WEIGHTED_RANDOM_SELECTOR_ASSERT_SVH
`define WEIGHTED_RANDOM_SELECTOR_ASSERT_SVH

// Invariant that holds on every clock edge outside reset.
`define WRS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Same-cycle implication.
`define WRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/wrs_pkg.sv =====
// Shared constants, codes and control types of the weighted random selector.
package wrs_pkg;

	localparam int ENTRIES_DEF     = 16;
	localparam int KEY_BITS_DEF    = 16;
	localparam int RANDOM_BITS_DEF = 31;

	localparam int OP_BITS     = 2;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 16;
	localparam int TOTAL_BITS  = 20;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD    = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_RETRY = 2'd1,
		ST_MISS  = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Which result the datapath stages
	typedef enum logic [2:0] {
		RES_MISS   = 3'd0,
		RES_RETRY  = 3'd1,
		RES_FULL   = 3'd2,
		RES_APPEND = 3'd3,
		RES_COUNT  = 3'd4,
		RES_INC    = 3'd5,
		RES_PICK   = 3'd6
	} res_t;

	typedef struct packed {
		logic capture;   // latch the input word, clear walk/divider
		logic rd;        // read table at walk index
		logic idx_inc;   // advance walk index
		logic cum_acc;   // add current count to cumulative sum
		logic div_step;  // one remainder step
		logic inc;       // bump count of the found entry
		logic app;       // append new key
		logic set_res;   // stage a result
		res_t res;
		logic out_load;  // move staged result to output register
	} wrs_cmd_t;

	typedef struct packed {
		logic [OP_BITS-1:0] op;
		logic used_zero;
		logic total_zero;
		logic full;
		logic key_hit;
		logic idx_last;
		logic div_last;
		logic reject;
		logic cum_hit;
	} wrs_sts_t;

endpackage

// ===== design/wrs_in_if.sv =====
// Input channel: valid/ready handshake carrying one request word.
interface wrs_in_if import wrs_pkg::*; #(
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int RANDOM_BITS = RANDOM_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [OP_BITS-1:0]     op;
	logic [KEY_BITS-1:0]    key;
	logic [RANDOM_BITS-1:0] random_word;

	modport source (output valid, output op, output key, output random_word, input ready);
	modport sink (input valid, input op, input key, input random_word, output ready);
endinterface

// ===== design/wrs_out_if.sv =====
// Output channel: valid/ready handshake carrying one result word.
interface wrs_out_if import wrs_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [KEY_BITS-1:0]    chosen_key;
	logic [COUNT_BITS-1:0]  weight;
	logic [TOTAL_BITS-1:0]  total;

	modport source (output valid, output status, output chosen_key, output weight,
		output total, input ready);
	modport sink (input valid, input status, input chosen_key, input weight,
		input total, output ready);
endinterface

// ===== design/wrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/wrs_ctrl.sv =====
// Controller state machine: sequences search, divide, walk and result handoff.
module wrs_ctrl import wrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	input  wrs_sts_t sts,
	output wrs_cmd_t cmd
);
	`include "weighted_random_selector_assert.svh"

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_DISP = 11'b00000000010,
		S_RD   = 11'b00000000100,
		S_CHK  = 11'b00000001000,
		S_INC  = 11'b00000010000,
		S_APP  = 11'b00000100000,
		S_DIV  = 11'b00001000000,
		S_REJ  = 11'b00010000000,
		S_WRD  = 11'b00100000000,
		S_WCHK = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_ADD: begin
						state_d = sts.used_zero ? S_APP : S_RD;
					end
					OP_QUERY: begin
						if (sts.used_zero) begin
							cmd.set_res = 1'b1;
							cmd.res     = RES_MISS;
							state_d     = S_OUT;
						end else begin
							state_d = S_RD;
						end
					end
					OP_SAMPLE: begin
						if (sts.used_zero || sts.total_zero) begin
							cmd.set_res = 1'b1;
							cmd.res     = RES_MISS;
							state_d     = S_OUT;
						end else begin
							state_d = S_DIV;
						end
					end
					default: begin
						cmd.set_res = 1'b1;
						cmd.res     = RES_MISS;
						state_d     = S_OUT;
					end
				endcase
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.key_hit) begin
					if (sts.op == OP_ADD) begin
						state_d = S_INC;
					end else begin
						cmd.set_res = 1'b1;
						cmd.res     = RES_COUNT;
						state_d     = S_OUT;
					end
				end else if (sts.idx_last) begin
					if (sts.op == OP_ADD && !sts.full) begin
						state_d = S_APP;
					end else begin
						cmd.set_res = 1'b1;
						cmd.res     = (sts.op == OP_ADD) ? RES_FULL : RES_MISS;
						state_d     = S_OUT;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_INC: begin
				cmd.inc     = 1'b1;
				cmd.set_res = 1'b1;
				cmd.res     = RES_INC;
				state_d     = S_OUT;
			end
			S_APP: begin
				cmd.app     = 1'b1;
				cmd.set_res = 1'b1;
				cmd.res     = RES_APPEND;
				state_d     = S_OUT;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_REJ;
				end
			end
			S_REJ: begin
				if (sts.reject) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_RETRY;
					state_d     = S_OUT;
				end else begin
					state_d = S_WRD;
				end
			end
			S_WRD: begin
				cmd.rd  = 1'b1;
				state_d = S_WCHK;
			end
			S_WCHK: begin
				if (sts.cum_hit) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_PICK;
					state_d     = S_OUT;
				end else if (sts.idx_last) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_MISS;
					state_d     = S_OUT;
				end else begin
					cmd.cum_acc = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = S_WRD;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`WRS_ASSERT_NEXT(a_disp_after_accept, in_valid && in_ready, state_q == S_DISP, "accepted word not dispatched")
	`WRS_ASSERT_IMP(a_rej_from_div, state_q == S_REJ, $past(state_q) == S_DIV, "reject check without divide")
	`WRS_ASSERT_NEXT(a_out_hold, state_q == S_OUT && out_valid_q && !out_ready, state_q == S_OUT, "staged result dropped")
endmodule

// ===== design/wrs_dpath.sv =====
// Datapath: key/count tables, fill count, total, remainder unit and result registers.
module wrs_dpath import wrs_pkg::*; #(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wrs_cmd_t               cmd,
	output wrs_sts_t               sts,
	input  logic [OP_BITS-1:0]     op,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [RANDOM_BITS-1:0] random_word,
	output logic [STATUS_BITS-1:0] status,
	output logic [KEY_BITS-1:0]    chosen_key,
	output logic [COUNT_BITS-1:0]  weight,
	output logic [TOTAL_BITS-1:0]  total
);
	`include "weighted_random_selector_assert.svh"

	localparam int IDX_BITS  = $clog2(ENTRIES);
	localparam int USED_BITS = $clog2(ENTRIES + 1);
	localparam int DIV_BITS  = $clog2(RANDOM_BITS);
	localparam int ACC_BITS  = (COUNT_BITS + IDX_BITS > TOTAL_BITS + 1) ?
		(COUNT_BITS + IDX_BITS) : (TOTAL_BITS + 1);
	localparam int CMP_BITS  = (RANDOM_BITS > TOTAL_BITS) ? RANDOM_BITS : TOTAL_BITS;
	localparam logic [RANDOM_BITS-1:0] RND_TOP = '1;

	// restoring remainder step: shift in one dividend bit, subtract if it fits
	function automatic logic [TOTAL_BITS-1:0] rem_step(input logic [TOTAL_BITS-1:0] rem,
		input logic din, input logic [TOTAL_BITS-1:0] dvs);
		logic [TOTAL_BITS:0] sh;
		sh = {rem, din};
		if (sh >= {1'b0, dvs}) begin
			sh = sh - {1'b0, dvs};
		end
		return sh[TOTAL_BITS-1:0];
	endfunction

	logic [OP_BITS-1:0]     op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [RANDOM_BITS-1:0] rnd_q;
	logic [RANDOM_BITS-1:0] rnd_sh_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic [USED_BITS-1:0]   used_q;
	logic [TOTAL_BITS-1:0]  total_q;
	logic [TOTAL_BITS-1:0]  rem_r_q;
	logic [TOTAL_BITS-1:0]  rem_t_q;
	logic [DIV_BITS-1:0]    div_cnt_q;
	logic [ACC_BITS-1:0]    cum_q;

	logic [STATUS_BITS-1:0] res_status_q, res_status_d;
	logic [KEY_BITS-1:0]    res_key_q, res_key_d;
	logic [COUNT_BITS-1:0]  res_weight_q, res_weight_d;

	logic [STATUS_BITS-1:0] status_q;
	logic [KEY_BITS-1:0]    chosen_key_q;
	logic [COUNT_BITS-1:0]  weight_q;
	logic [TOTAL_BITS-1:0]  total_out_q;

	logic [KEY_BITS-1:0]    key_rd;
	logic [COUNT_BITS-1:0]  cnt_rd;
	logic                   cnt_sat;
	logic [COUNT_BITS-1:0]  cnt_inc;
	logic [ACC_BITS-1:0]    cum_next;
	logic [TOTAL_BITS:0]    target;
	logic [TOTAL_BITS-1:0]  total_inc;
	logic [IDX_BITS-1:0]    cnt_waddr;
	logic [COUNT_BITS-1:0]  cnt_wdata;

	wrs_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (cmd.app),
		.waddr (used_q[IDX_BITS-1:0]),
		.wdata (key_q),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (key_rd)
	);

	assign cnt_waddr = cmd.app ? used_q[IDX_BITS-1:0] : idx_q;
	assign cnt_wdata = cmd.app ? COUNT_BITS'(1) : cnt_inc;

	wrs_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES)) u_cnt_ram (
		.clk   (clk),
		.we    (cmd.app || cmd.inc),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (cnt_rd)
	);

	assign cnt_sat   = (cnt_rd == COUNT_MAX);
	assign cnt_inc   = cnt_sat ? cnt_rd : cnt_rd + 1'b1;
	assign total_inc = (total_q == TOTAL_MAX) ? total_q : total_q + 1'b1;
	assign cum_next  = cum_q + ACC_BITS'(cnt_rd);
	assign target    = {1'b0, rem_r_q} + 1'b1;

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.used_zero  = (used_q == '0);
		sts.total_zero = (total_q == '0);
		sts.full       = (used_q == USED_BITS'(ENTRIES));
		sts.key_hit    = (key_rd == key_q);
		sts.idx_last   = (USED_BITS'(idx_q) + 1'b1 == used_q);
		sts.div_last   = (div_cnt_q == DIV_BITS'(RANDOM_BITS - 1));
		// biased tail: word at or above the largest multiple of the total
		sts.reject     = (CMP_BITS'(rnd_q) >= CMP_BITS'(RND_TOP) - CMP_BITS'(rem_t_q));
		sts.cum_hit    = (ACC_BITS'(target) <= cum_next);
	end

	always_comb begin
		res_status_d = ST_MISS;
		res_key_d    = key_q;
		res_weight_d = '0;
		case (cmd.res)
			RES_MISS: begin
				res_status_d = ST_MISS;
			end
			RES_RETRY: begin
				res_status_d = ST_RETRY;
			end
			RES_FULL: begin
				res_status_d = ST_FULL;
			end
			RES_APPEND: begin
				res_status_d = ST_OK;
				res_weight_d = COUNT_BITS'(1);
			end
			RES_COUNT: begin
				res_status_d = ST_OK;
				res_weight_d = cnt_rd;
			end
			RES_INC: begin
				res_status_d = ST_OK;
				res_weight_d = cnt_inc;
			end
			RES_PICK: begin
				res_status_d = ST_OK;
				res_key_d    = key_rd;
				res_weight_d = cnt_rd;
			end
			default: begin
				res_status_d = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			total_q   <= '0;
			idx_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.capture) begin
				idx_q     <= '0;
				div_cnt_q <= '0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmd.div_step) begin
					div_cnt_q <= div_cnt_q + 1'b1;
				end
			end
			if (cmd.app) begin
				used_q  <= used_q + 1'b1;
				total_q <= total_inc;
			end else if (cmd.inc && !cnt_sat) begin
				total_q <= total_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			key_q    <= key;
			rnd_q    <= random_word;
			rnd_sh_q <= random_word;
			rem_r_q  <= '0;
			rem_t_q  <= '0;
			cum_q    <= '0;
		end else begin
			if (cmd.div_step) begin
				rem_r_q  <= rem_step(rem_r_q, rnd_sh_q[RANDOM_BITS-1], total_q);
				rem_t_q  <= rem_step(rem_t_q, 1'b1, total_q);
				rnd_sh_q <= rnd_sh_q << 1;
			end
			if (cmd.cum_acc) begin
				cum_q <= cum_next;
			end
		end
		if (cmd.set_res) begin
			res_status_q <= res_status_d;
			res_key_q    <= res_key_d;
			res_weight_q <= res_weight_d;
		end
		if (cmd.out_load) begin
			status_q     <= res_status_q;
			chosen_key_q <= res_key_q;
			weight_q     <= res_weight_q;
			total_out_q  <= total_q;
		end
	end

	assign status     = status_q;
	assign chosen_key = chosen_key_q;
	assign weight     = weight_q;
	assign total      = total_out_q;

	`WRS_ASSERT(a_used_bound, used_q <= USED_BITS'(ENTRIES), "fill count beyond table depth")
	`WRS_ASSERT(a_total_step, (total_q == $past(total_q)) || (total_q == $past(total_q) + 1'b1), "total moved by more than one")
	`WRS_ASSERT_NEXT(a_rem_range, cmd.div_step, (rem_r_q < total_q) && (rem_t_q < total_q), "remainder not below total")
endmodule

// ===== design/weighted_random_selector.sv =====
// Top level of the weighted random selector: controller plus datapath behind two channels.
// One word in flight at a time; the result sits in an output register so the next word
// is taken as soon as the result is handed to that register.
// Add/query: a RAM read and a compare per table entry searched.
// Sample: RANDOM_BITS remainder steps, then a RAM read and a check per entry walked.
// Reset clears fill count, total and control; table RAMs are not cleared (fill count guards).
module weighted_random_selector import wrs_pkg::*; #(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wrs_in_if.sink    item,
	wrs_out_if.source result
);
	// Command/status pair between the sequencer and the datapath
	wrs_cmd_t cmd;
	wrs_sts_t sts;

	// Sequencer: owns the handshake on both channels. The input is ready only while
	// idle; the output valid flag lives here so the controller holds the next result
	// back while a stalled one is still waiting to be taken.
	wrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: key and count RAMs (read one entry per visit), fill count, running
	// total, a two-lane restoring remainder unit (random word mod total and
	// all-ones mod total in lockstep), the cumulative walk and the result registers.
	wrs_dpath #(
		.ENTRIES     (ENTRIES),
		.KEY_BITS    (KEY_BITS),
		.RANDOM_BITS (RANDOM_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (item.op),
		.key         (item.key),
		.random_word (item.random_word),
		.status      (result.status),
		.chosen_key  (result.chosen_key),
		.weight      (result.weight),
		.total       (result.total)
	);
endmodule

// ===== verif/wrs_checker.sv =====
// Checker for the weighted random selector: table predictor plus in-order result compare.
module wrs_checker import wrs_pkg::*; #(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [OP_BITS-1:0]     in_op,
	input  logic [KEY_BITS-1:0]    in_key,
	input  logic [RANDOM_BITS-1:0] in_random_word,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [STATUS_BITS-1:0] out_status,
	input  logic [KEY_BITS-1:0]    out_chosen_key,
	input  logic [COUNT_BITS-1:0]  out_weight,
	input  logic [TOTAL_BITS-1:0]  out_total,
	output int                     errors,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t               status;
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] weight;
		logic [TOTAL_BITS-1:0] total;
	} reply_t;

	// mirror of the key table, raw counts only
	logic [KEY_BITS-1:0]   tbl_key [ENTRIES];
	logic [COUNT_BITS-1:0] tbl_count [ENTRIES];
	int unsigned           n_used;
	logic [TOTAL_BITS-1:0] sum_counts;

	reply_t expected_replies[$];
	reply_t want;

	task automatic report_mismatch(input string what, input longint unsigned got,
		input longint unsigned exp_val);
		errors++;
		if (errors <= 100) begin
			$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
				$time, what, got, exp_val);
		end
	endtask

	function automatic int find_key(input logic [KEY_BITS-1:0] k);
		for (int i = 0; i < int'(n_used); i++) begin
			if (tbl_key[i] == k) begin
				return i;
			end
		end
		return -1;
	endfunction

	// Applies one word to the table mirror and returns the reply it should produce.
	function automatic reply_t table_response(input logic [OP_BITS-1:0] op,
		input logic [KEY_BITS-1:0] k, input logic [RANDOM_BITS-1:0] rw);
		reply_t r;
		int slot;
		longint unsigned top, tot, target, cum;
		bit hit;
		r.status = ST_MISS;
		r.key    = k;
		r.weight = '0;
		case (op)
			OP_ADD: begin
				slot = find_key(k);
				if (slot >= 0) begin
					if (tbl_count[slot] != COUNT_MAX) begin
						tbl_count[slot]++;
						if (sum_counts != TOTAL_MAX) begin
							sum_counts++;
						end
					end
					r.status = ST_OK;
					r.weight = tbl_count[slot];
				end else if (n_used >= ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					tbl_key[n_used]   = k;
					tbl_count[n_used] = COUNT_BITS'(1);
					n_used++;
					if (sum_counts != TOTAL_MAX) begin
						sum_counts++;
					end
					r.status = ST_OK;
					r.weight = COUNT_BITS'(1);
				end
			end
			OP_SAMPLE: begin
				top = (64'd1 << RANDOM_BITS) - 1;
				tot = sum_counts;
				if (tot != 0 && n_used != 0) begin
					if (rw >= top - (top % tot)) begin
						r.status = ST_RETRY;
					end else begin
						// walk the cumulative sum of raw counts
						target = (rw % tot) + 1;
						cum    = 0;
						hit    = 1'b0;
						for (int i = 0; i < int'(n_used); i++) begin
							cum += tbl_count[i];
							if (!hit && target <= cum) begin
								hit      = 1'b1;
								r.status = ST_OK;
								r.key    = tbl_key[i];
								r.weight = tbl_count[i];
							end
						end
					end
				end
			end
			OP_QUERY: begin
				slot = find_key(k);
				if (slot >= 0) begin
					r.status = ST_OK;
					r.weight = tbl_count[slot];
				end
			end
			default: begin
			end
		endcase
		r.total = sum_counts;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors     = 0;
			n_used     = 0;
			sum_counts = '0;
			foreach (tbl_count[i]) begin
				tbl_count[i] = '0;
				tbl_key[i]   = '0;
			end
			expected_replies.delete();
		end else begin
			if (in_valid && in_ready) begin
				expected_replies.insert(expected_replies.size(),
					table_response(in_op, in_key, in_random_word));
			end
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected result word", out_chosen_key, '0);
				end else begin
					want = expected_replies.pop_front();
					if (out_status != want.status)
						report_mismatch("status", out_status, want.status);
					if (out_chosen_key != want.key)
						report_mismatch("chosen_key", out_chosen_key, want.key);
					if (out_weight != want.weight)
						report_mismatch("weight", out_weight, want.weight);
					if (out_total != want.total)
						report_mismatch("total", out_total, want.total);
				end
			end
		end
		pending = expected_replies.size();
	end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the weighted random selector: stimulus, flow control and verdict.
module tb_top import wrs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// op code the block leaves unused; it must answer with a miss and touch nothing
	localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;

	localparam logic [RANDOM_BITS_DEF-1:0] WORD_MAX = '1;
	localparam int POOL_SIZE     = 24;   // more keys than table entries, so full shows up
	localparam int STALL_LIMIT   = 4000; // cycles with no word moving on either channel
	localparam int DRAIN_CYCLES  = 100;  // beyond the worst sample latency
	localparam int PHASE_WORDS   = 90;

	logic clk;
	logic arst_n;

	int src_idle_pct;
	int sink_stall_pct;
	int idle_cycles = 0;
	int errors;
	int pending;

	logic [KEY_BITS_DEF-1:0] key_pool [POOL_SIZE];

	wrs_in_if #(.KEY_BITS(KEY_BITS_DEF), .RANDOM_BITS(RANDOM_BITS_DEF)) item_ch ();
	wrs_out_if #(.KEY_BITS(KEY_BITS_DEF)) result_ch ();

	weighted_random_selector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// The checker watches both channels on its own; the top only reads back
	// its error count and how many results are still owed.
	wrs_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (item_ch.valid),
		.in_ready       (item_ch.ready),
		.in_op          (item_ch.op),
		.in_key         (item_ch.key),
		.in_random_word (item_ch.random_word),
		.out_valid      (result_ch.valid),
		.out_ready      (result_ch.ready),
		.out_status     (result_ch.status),
		.out_chosen_key (result_ch.chosen_key),
		.out_weight     (result_ch.weight),
		.out_total      (result_ch.total),
		.errors         (errors),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side back-pressure: one fresh ready decision per falling edge.
	always @(negedge clk) begin
		result_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Watchdog: any accepted word on either side proves the block is alive.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Present one word at a falling edge and hold it until the block takes it.
	// Valid is left high on return so back-to-back words never see a glitch;
	// the next call either re-drives it or drops it for an idle cycle.
	task automatic send_word(input logic [OP_BITS-1:0] word_op,
		input logic [KEY_BITS_DEF-1:0] word_key,
		input logic [RANDOM_BITS_DEF-1:0] word_rand);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid       = 1'b1;
		item_ch.op          = word_op;
		item_ch.key         = word_key;
		item_ch.random_word = word_rand;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	// One random word. Most traffic is adds and samples over a fixed key pool
	// so the table fills, counts grow and the walk covers every slot; the rest
	// is queries, adds of stray keys (mostly full once the table is packed)
	// and the unused op.
	task automatic send_random_word();
		int pick;
		logic [OP_BITS-1:0] word_op;
		logic [KEY_BITS_DEF-1:0] word_key;
		logic [RANDOM_BITS_DEF-1:0] word_rand;
		pick      = $urandom_range(0, 99);
		word_key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		word_rand = RANDOM_BITS_DEF'($urandom);
		if (pick < 40) begin
			word_op = OP_ADD;
		end else if (pick < 75) begin
			word_op  = OP_SAMPLE;
			word_key = KEY_BITS_DEF'($urandom);
			// push some draws into the biased tail so retries happen
			if ($urandom_range(0, 4) == 0) begin
				word_rand = WORD_MAX - RANDOM_BITS_DEF'($urandom_range(0, 4095));
			end
		end else if (pick < 90) begin
			word_op = OP_QUERY;
			if ($urandom_range(0, 2) == 0) begin
				word_key = KEY_BITS_DEF'($urandom);
			end
		end else if (pick < 95) begin
			word_op  = OP_ADD;
			word_key = KEY_BITS_DEF'($urandom);
		end else begin
			word_op  = OP_NONE;
			word_key = KEY_BITS_DEF'($urandom);
		end
		send_word(word_op, word_key, word_rand);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n_words);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		repeat (n_words) send_random_word();
	endtask

	initial begin
		item_ch.valid       = 1'b0;
		item_ch.op          = OP_ADD;
		item_ch.key         = '0;
		item_ch.random_word = '0;
		src_idle_pct        = 0;
		sink_stall_pct      = 0;
		arst_n              = 1'b0;

		// pool: both extreme keys plus random ones; slot 0 will hold key 0
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			key_pool[i] = KEY_BITS_DEF'($urandom_range(1, 16'hFFFE));
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed: empty table, first entries, edges of the random word ---
		send_word(OP_SAMPLE, 16'hFFFF, '0);                 // sample with nothing stored
		send_word(OP_QUERY, 16'h1234, '1);                  // query on empty table
		send_word(OP_NONE, 16'hA5A5, '1);                   // unused op
		send_word(OP_ADD, 16'h0000, '0);                    // append
		send_word(OP_ADD, 16'h0000, '0);                    // increment existing
		send_word(OP_ADD, 16'hFFFF, '1);                    // append top key
		send_word(OP_QUERY, 16'hFFFF, '0);
		send_word(OP_QUERY, 16'h0000, '0);
		send_word(OP_SAMPLE, 16'h5A5A, '0);                 // lowest word picks first slot
		send_word(OP_SAMPLE, 16'hA5A5, 31'd2);              // lands in second slot
		send_word(OP_SAMPLE, 16'h0F0F, WORD_MAX);           // top word always rejected
		send_word(OP_SAMPLE, 16'hF0F0, WORD_MAX - 31'd1);   // edge of the tail, total 3
		send_word(OP_SAMPLE, 16'h3C3C, WORD_MAX - 31'd2);   // just below the tail
		send_word(OP_NONE, 16'h0000, '0);                   // unused op on a present key
		send_word(OP_QUERY, 16'h5555, '0);                  // absent key

		// --- random traffic under each flow-control mix ---
		run_phase(0, 0, PHASE_WORDS);
		run_phase(54, 0, PHASE_WORDS);
		run_phase(0, 54, PHASE_WORDS);
		run_phase(34, 34, PHASE_WORDS);

		// --- fill to the brim, then samples over the packed table ---
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		foreach (key_pool[i]) begin
			send_word(OP_ADD, key_pool[i], RANDOM_BITS_DEF'($urandom));
		end
		// likely one more for full
		send_word(OP_ADD, 16'hBEEF ^ key_pool[2], RANDOM_BITS_DEF'($urandom));
		send_word(OP_QUERY, key_pool[0], '0);
		send_word(OP_SAMPLE, 16'h1111, '0);
		send_word(OP_SAMPLE, 16'h2222, WORD_MAX);
		repeat (8) send_word(OP_SAMPLE, KEY_BITS_DEF'($urandom), RANDOM_BITS_DEF'($urandom));

		item_ch.valid = 1'b0;

		// let the last results drain, then give a little slack for stray words
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/wrs_pkg.sv
design/wrs_in_if.sv
design/wrs_out_if.sv
design/wrs_ram.sv
design/wrs_ctrl.sv
design/wrs_dpath.sv
design/weighted_random_selector.sv
verif/wrs_checker.sv
verif/tb_top.sv
